FILE: hw/rtl/imu_complementary_tilt_filter_assert.svh
// assertion macros for the tilt filter
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TF_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define TF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/imu_tf_pkg.sv
`default_nettype none
package imu_tf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORD_N       = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int CNT_W        = $clog2(ATAN_LEN);

  localparam int SAMP_W  = 16;
  localparam int ANG_W   = 32;
  localparam int CXY_W   = 28;
  localparam int CZ_W    = 27;
  localparam int INC_W   = 22;
  localparam int NUM_W   = 29;
  localparam int RECIP_W = 30;
  localparam int PROD_W  = NUM_W + RECIP_W;
  localparam int REC_SH  = 36;
  localparam int Q_W     = PROD_W - REC_SH;
  localparam int DIFF_W  = 33;
  localparam int WACC_W  = 12;
  localparam int BLEND_W = DIFF_W + WACC_W;
  localparam int SUM_W   = 34;

  // floor(n/2000) == floor((4096*g + 62)/125), biased positive, times ceil(2^36/125)
  localparam logic [RECIP_W-1:0] RECIP    = 30'd549755814;
  localparam logic [NUM_W-1:0]   NUM_BIAS = 29'd262144062;
  localparam logic [Q_W-1:0]     Q_BIAS   = 23'd2097152;

  localparam logic signed [CZ_W-1:0]    DEG180     = 27'sd11796480;
  localparam logic signed [WACC_W-1:0]  W_ACC      = 12'sd1311;
  localparam logic signed [BLEND_W-1:0] ROUND_HALF = 45'sd32768;

  typedef enum logic [2:0] {
    CFG_AX = 3'd0,
    CFG_AY = 3'd1,
    CFG_AZ = 3'd2,
    CFG_GX = 3'd3,
    CFG_GY = 3'd4,
    CFG_GZ = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    G_X = 2'd0,
    G_Y = 2'd1,
    G_Z = 2'd2
  } gsel_t;

  typedef struct packed {
    logic             load;
    logic             cinit;
    logic             gmul;
    logic             gadd;
    logic [1:0]       gsel;
    logic             cstep;
    logic [CNT_W-1:0] step;
    logic             bmul;
    logic             commit;
  } cmd_t;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic [21:0] atan_q16(input logic [CNT_W-1:0] i);
    logic [21:0] r;
    case (i)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      5'd20:   r = 22'd4;
      5'd21:   r = 22'd2;
      5'd22:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [SUM_W-1:0] v);
    logic signed [ANG_W-1:0] r;
    if (v > $signed({{(SUM_W-ANG_W+1){1'b0}}, {(ANG_W-1){1'b1}}})) begin
      r = {1'b0, {(ANG_W-1){1'b1}}};
    end else if (v < $signed({{(SUM_W-ANG_W+1){1'b1}}, {(ANG_W-1){1'b0}}})) begin
      r = {1'b1, {(ANG_W-1){1'b0}}};
    end else begin
      r = v[ANG_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/imu_complementary_tilt_filter.sv
// channel   direction  handshake            payload
// in_       request in  in_valid/in_stall    accel_x..z, gyro_x..z (16b signed)
// out_      request out out_valid/out_stall  roll, pitch, yaw angle (32b Q16.16)
// cfg_      write in    cfg_valid/cfg_ready  cfg_index (3b), cfg_data (16b)
//
// a new request is taken only in the idle state; in_stall is high while busy
// gyro increment for each axis through one shared reciprocal multiplier,
// then CORDIC_STEPS iterations of the two atan2 lanes, then the blend
// synchronous active-low reset clears angles and offsets to zero
// a finished result waits in the output register; the next request is
// taken meanwhile and its commit waits until the old result is taken
`default_nettype none
module imu_complementary_tilt_filter (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [15:0]  in_accel_x,
  input  wire logic signed [15:0]  in_accel_y,
  input  wire logic signed [15:0]  in_accel_z,
  input  wire logic signed [15:0]  in_gyro_x,
  input  wire logic signed [15:0]  in_gyro_y,
  input  wire logic signed [15:0]  in_gyro_z,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       out_roll_angle,
  output logic signed [31:0]       out_pitch_angle,
  output logic signed [31:0]       out_yaw_angle,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  imu_tf_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  imu_tf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  imu_tf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accel_x     (in_accel_x),
    .accel_y     (in_accel_y),
    .accel_z     (in_accel_z),
    .gyro_x      (in_gyro_x),
    .gyro_y      (in_gyro_y),
    .gyro_z      (in_gyro_z),
    .roll_angle  (out_roll_angle),
    .pitch_angle (out_pitch_angle),
    .yaw_angle   (out_yaw_angle)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/imu_tf_ctrl.sv
`default_nettype none
module imu_tf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output imu_tf_pkg::cmd_t     cmd
);

  `include "imu_complementary_tilt_filter_assert.svh"

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CINIT = 7'b0000010,
    S_GMUL  = 7'b0000100,
    S_GADD  = 7'b0001000,
    S_CORD  = 7'b0010000,
    S_BMUL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [imu_tf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           accept, out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CINIT;
      end
      S_CINIT: begin
        state_nxt = S_GMUL;
        cnt_nxt   = '0;
      end
      S_GMUL: state_nxt = S_GADD;
      S_GADD: begin
        if (cnt_r == imu_tf_pkg::CNT_W'(imu_tf_pkg::G_Z)) begin
          state_nxt = S_CORD;
          cnt_nxt   = '0;
        end else begin
          state_nxt = S_GMUL;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      S_CORD: begin
        if (cnt_r == imu_tf_pkg::CNT_W'(imu_tf_pkg::CORD_N - 1)) begin
          state_nxt = S_BMUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_BMUL: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.cinit  = (state_r == S_CINIT);
    cmd.gmul   = (state_r == S_GMUL);
    cmd.gadd   = (state_r == S_GADD);
    cmd.gsel   = cnt_r[1:0];
    cmd.cstep  = (state_r == S_CORD);
    cmd.step   = cnt_r;
    cmd.bmul   = (state_r == S_BMUL);
    cmd.commit = (state_r == S_DONE) && out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TF_ASSERT_NXT(a_accept_init, clk, rst_n, accept, state_r == S_CINIT, "accept did not start work")
  `TF_ASSERT_IMP(a_commit_free, clk, rst_n, cmd.commit, !(out_valid_r && out_stall), "result overwritten")
  `TF_ASSERT_IMP(a_cord_range, clk, rst_n, state_r == S_CORD, cnt_r < imu_tf_pkg::CNT_W'(imu_tf_pkg::CORD_N), "cordic step out of range")
  `TF_ASSERT_IMP(a_valid_src, clk, rst_n, $rose(out_valid_r), $past(state_r == S_DONE), "result raised outside commit")

endmodule
`default_nettype wire

FILE: hw/rtl/imu_tf_dp.sv
`default_nettype none
module imu_tf_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire imu_tf_pkg::cmd_t     cmd,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic signed [15:0]   accel_x,
  input  wire logic signed [15:0]   accel_y,
  input  wire logic signed [15:0]   accel_z,
  input  wire logic signed [15:0]   gyro_x,
  input  wire logic signed [15:0]   gyro_y,
  input  wire logic signed [15:0]   gyro_z,
  output logic signed [31:0]        roll_angle,
  output logic signed [31:0]        pitch_angle,
  output logic signed [31:0]        yaw_angle
);

  localparam int SW = imu_tf_pkg::SAMP_W;
  localparam int AW = imu_tf_pkg::ANG_W;
  localparam int XW = imu_tf_pkg::CXY_W;
  localparam int ZW = imu_tf_pkg::CZ_W;

  logic [SW-1:0] off_r [6];
  logic signed [SW-1:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;

  logic signed [XW-1:0] cx_r [2];
  logic signed [XW-1:0] cy_r [2];
  logic signed [ZW-1:0] cz_r [2];
  logic                 czero_r [2];

  logic [imu_tf_pkg::PROD_W-1:0]         prod_r;
  logic signed [AW-1:0]                  t_r [3];
  logic signed [imu_tf_pkg::BLEND_W-1:0] bx_r [2];
  logic signed [AW-1:0]                  roll_r, pitch_r, yaw_r;

  // offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) off_r[k] <= '0;
    end else if (cfg_we) begin
      unique case (imu_tf_pkg::cfg_idx_t'(cfg_index))
        imu_tf_pkg::CFG_AX: off_r[0] <= cfg_data;
        imu_tf_pkg::CFG_AY: off_r[1] <= cfg_data;
        imu_tf_pkg::CFG_AZ: off_r[2] <= cfg_data;
        imu_tf_pkg::CFG_GX: off_r[3] <= cfg_data;
        imu_tf_pkg::CFG_GY: off_r[4] <= cfg_data;
        imu_tf_pkg::CFG_GZ: off_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // offset removal wraps to 16 bits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= accel_x - $signed(off_r[0]);
      ay_r <= accel_y - $signed(off_r[1]);
      az_r <= accel_z - $signed(off_r[2]);
      gx_r <= gyro_x - $signed(off_r[3]);
      gy_r <= gyro_y - $signed(off_r[4]);
      gz_r <= gyro_z - $signed(off_r[5]);
    end
  end

  // gyro increment: reciprocal multiply, then add to kept angle
  logic signed [SW-1:0]               g_sel;
  logic [imu_tf_pkg::NUM_W-1:0]       num;
  logic [imu_tf_pkg::Q_W-1:0]         q_raw;
  logic signed [imu_tf_pkg::INC_W-1:0] inc;
  logic signed [AW-1:0]               base;
  logic signed [imu_tf_pkg::SUM_W-1:0] gsum;

  always_comb begin
    case (imu_tf_pkg::gsel_t'(cmd.gsel))
      imu_tf_pkg::G_X: begin g_sel = gx_r; base = roll_r;  end
      imu_tf_pkg::G_Y: begin g_sel = gy_r; base = pitch_r; end
      default:         begin g_sel = gz_r; base = yaw_r;   end
    endcase
    num   = imu_tf_pkg::NUM_W'({{(imu_tf_pkg::NUM_W-SW-12){g_sel[SW-1]}}, g_sel, 12'b0})
            + imu_tf_pkg::NUM_BIAS;
    q_raw = prod_r[imu_tf_pkg::PROD_W-1:imu_tf_pkg::REC_SH] - imu_tf_pkg::Q_BIAS;
    inc   = $signed(q_raw[imu_tf_pkg::INC_W-1:0]);
    gsum  = imu_tf_pkg::SUM_W'(base) + imu_tf_pkg::SUM_W'(inc);
  end

  always_ff @(posedge clk) begin
    if (cmd.gmul) prod_r <= imu_tf_pkg::PROD_W'(num) * imu_tf_pkg::PROD_W'(imu_tf_pkg::RECIP);
    if (cmd.gadd) t_r[cmd.gsel] <= imu_tf_pkg::sat_ang(gsum);
  end

  // cordic lanes: 0 roll (ay, az), 1 pitch (ax, az)
  logic signed [SW-1:0] ly [2];
  logic signed [SW-1:0] lx;
  assign ly[0] = ay_r;
  assign ly[1] = ax_r;
  assign lx    = az_r;

  logic signed [XW-1:0] xs [2];
  logic signed [XW-1:0] ys [2];
  logic signed [ZW-1:0] at;
  logic                 ypos [2];

  always_comb begin
    at = ZW'($signed({1'b0, imu_tf_pkg::atan_q16(cmd.step)}));
    for (int l = 0; l < 2; l++) begin
      xs[l]   = cx_r[l] >>> cmd.step;
      ys[l]   = cy_r[l] >>> cmd.step;
      ypos[l] = !cy_r[l][XW-1] && (cy_r[l] != '0);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd.cinit) begin
        czero_r[l] <= (lx == '0) && (ly[l] == '0);
        if (lx[SW-1]) begin
          // pre-rotate by 180 degrees
          cz_r[l] <= ly[l][SW-1] ? -imu_tf_pkg::DEG180 : imu_tf_pkg::DEG180;
          cx_r[l] <= -(XW'(lx) <<< 8);
          cy_r[l] <= -(XW'(ly[l]) <<< 8);
        end else begin
          cz_r[l] <= '0;
          cx_r[l] <= XW'(lx) <<< 8;
          cy_r[l] <= XW'(ly[l]) <<< 8;
        end
      end else if (cmd.cstep) begin
        if (ypos[l]) begin
          cx_r[l] <= cx_r[l] + ys[l];
          cy_r[l] <= cy_r[l] - xs[l];
          cz_r[l] <= cz_r[l] + at;
        end else begin
          cx_r[l] <= cx_r[l] - ys[l];
          cy_r[l] <= cy_r[l] + xs[l];
          cz_r[l] <= cz_r[l] - at;
        end
      end
    end
  end

  // blend: t + floor((1311*(a - t) + 32768) / 65536)
  logic signed [imu_tf_pkg::DIFF_W-1:0] diff [2];
  logic signed [imu_tf_pkg::SUM_W-1:0]  bsum [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      diff[l] = (czero_r[l] ? '0 : imu_tf_pkg::DIFF_W'(cz_r[l]))
                - imu_tf_pkg::DIFF_W'(t_r[l]);
      bsum[l] = imu_tf_pkg::SUM_W'(t_r[l])
                + imu_tf_pkg::SUM_W'(bx_r[l] >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bmul) begin
      for (int l = 0; l < 2; l++) begin
        bx_r[l] <= imu_tf_pkg::BLEND_W'(diff[l]) * imu_tf_pkg::BLEND_W'(imu_tf_pkg::W_ACC)
                   + imu_tf_pkg::ROUND_HALF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
    end else if (cmd.commit) begin
      roll_r  <= imu_tf_pkg::sat_ang(bsum[0]);
      pitch_r <= imu_tf_pkg::sat_ang(bsum[1]);
      yaw_r   <= t_r[2];
    end
  end

  assign roll_angle  = roll_r;
  assign pitch_angle = pitch_r;
  assign yaw_angle   = yaw_r;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
  } angles_t;

  typedef logic signed [15:0] sample_t [6];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic signed [15:0] in_gyro_x = '0, in_gyro_y = '0, in_gyro_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_roll_angle, out_pitch_angle, out_yaw_angle;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;

  // predictor state
  logic [15:0] offset_q [6];
  longint roll_q, pitch_q, yaw_q;
  angles_t angle_queue [$];

  localparam longint ATAN_DEG [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  always #2 clk = ~clk;

  imu_complementary_tilt_filter u_top (.*);

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rate_step(longint g);
    return fdiv(g * 65536 + 1000, 2000);
  endfunction

  function automatic longint tilt_atan2(longint y, longint x);
    longint z, xs, ys;
    int n;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // left half plane: flip by 180 degrees first
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    x *= 256;
    y *= 256;
    n = (imu_tf_pkg::CORDIC_STEPS > 24) ? 24 : imu_tf_pkg::CORDIC_STEPS;
    for (int i = 0; i < n; i++) begin
      xs = fdiv(x, longint'(1) << i);
      ys = fdiv(y, longint'(1) << i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z += ATAN_DEG[i];
      end else begin
        x = x - ys; y = y + xs; z -= ATAN_DEG[i];
      end
    end
    return z;
  endfunction

  function automatic longint blend_tilt(longint kept, longint g, longint num, longint den);
    longint t, a;
    t = clamp32(kept + rate_step(g));
    a = tilt_atan2(num, den);
    return clamp32(fdiv(64225 * t + 1311 * a + 32768, 65536));
  endfunction

  function automatic void predict_angles(sample_t s);
    longint v [6];
    logic signed [15:0] d;
    angles_t e;
    for (int i = 0; i < 6; i++) begin
      d = s[i] - offset_q[i];
      v[i] = d;
    end
    roll_q = blend_tilt(roll_q, v[3], v[1], v[2]);
    pitch_q = blend_tilt(pitch_q, v[4], v[0], v[2]);
    yaw_q = clamp32(yaw_q + rate_step(v[5]));
    e.roll = roll_q[31:0];
    e.pitch = pitch_q[31:0];
    e.yaw = yaw_q[31:0];
    angle_queue.push_back(e);
  endfunction

  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_accel_x <= s[0]; in_accel_y <= s[1]; in_accel_z <= s[2];
    in_gyro_x <= s[3]; in_gyro_y <= s[4]; in_gyro_z <= s[5];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_angles(s);
    n_sent++;
  endtask

  task automatic write_offset(imu_tf_pkg::cfg_idx_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    offset_q[idx] = value;
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (angle_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    angles_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (angle_queue.size() == 0) begin
        $error("result with no request pending");
        n_errors++;
      end else begin
        e = angle_queue.pop_front();
        n_checked++;
        if (out_roll_angle !== e.roll) begin
          $error("roll_angle expected %0d got %0d", e.roll, out_roll_angle);
          n_errors++;
        end
        if (out_pitch_angle !== e.pitch) begin
          $error("pitch_angle expected %0d got %0d", e.pitch, out_pitch_angle);
          n_errors++;
        end
        if (out_yaw_angle !== e.yaw) begin
          $error("yaw_angle expected %0d got %0d", e.yaw, out_yaw_angle);
          n_errors++;
        end
      end
    end
  end

  function automatic sample_t rand_sample();
    sample_t s;
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(5))
        0: s[i] = 16'sh8000;
        1: s[i] = 16'sh7fff;
        2: s[i] = 16'($urandom_range(8)) - 16'sd4;
        default: s[i] = 16'($urandom);
      endcase
    end
    return s;
  endfunction

  task automatic test_directed;
    sample_t s;
    logic signed [15:0] pts [8] = '{16'sh8000, 16'sh7fff, 0, 1, -1, 16'sd1000,
                                     -16'sd1000, 16'sd16384};
    // zero vector, axis cases and negative x operand with y sign both ways
    for (int i = 0; i < 8; i++) begin
      s = '{pts[i], pts[(i + 3) % 8], pts[(i + 5) % 8], pts[i], pts[7 - i], pts[i]};
      send_sample(s);
    end
    s = '{0, 0, 0, 0, 0, 0}; send_sample(s);
    s = '{0, 0, -16'sd500, 0, 0, 0}; send_sample(s);
    s = '{-16'sd300, 16'sd300, -16'sd500, 16'sd999, 16'sd1000, -16'sd1000}; send_sample(s);
    s = '{16'sd300, -16'sd300, -16'sd500, -16'sd999, -16'sd1001, 16'sd1001}; send_sample(s);
    // push yaw toward positive saturation
    for (int i = 0; i < 12; i++) begin
      s = '{0, 0, 16'sd100, 16'sh7fff, 16'sh7fff, 16'sh7fff};
      send_sample(s);
    end
    drain();
  endtask

  task automatic test_offsets;
    // wraparound through extreme offsets
    write_offset(imu_tf_pkg::CFG_AX, 16'h8000);
    write_offset(imu_tf_pkg::CFG_AY, 16'h7fff);
    write_offset(imu_tf_pkg::CFG_AZ, 16'hffff);
    write_offset(imu_tf_pkg::CFG_GX, 16'h8000);
    write_offset(imu_tf_pkg::CFG_GY, 16'h7fff);
    write_offset(imu_tf_pkg::CFG_GZ, 16'h8000);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 40; i++) send_sample(rand_sample());
    drain();
    for (int i = 0; i < 6; i++) write_offset(imu_tf_pkg::cfg_idx_t'(i), 16'($urandom));
    cfg_valid <= 1'b0;
    for (int i = 0; i < 40; i++) send_sample(rand_sample());
    drain();
    for (int i = 0; i < 6; i++) write_offset(imu_tf_pkg::cfg_idx_t'(i), 16'h0000);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) send_sample(rand_sample());
    drain();
  endtask

  initial begin
    for (int i = 0; i < 6; i++) offset_q[i] = '0;
    roll_q = 0; pitch_q = 0; yaw_q = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_offsets();
    test_random(250, 0, 0);
    test_random(230, 69, 0);
    test_random(230, 0, 69);
    test_random(230, 30, 30);
    $display("sent %0d samples, checked %0d angle results", n_sent, n_checked);
    $display("covered offset wrap, atan2 quadrants and handshake pressure");
    if (n_errors == 0 && angle_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
